### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the framer modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked at every clock edge outside reset
`define ASSERT_CHK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### rtl/tpf_pkg.sv
// ---------------------------------------------------------------------------
// tpf_pkg
// types, packet constants and the crc-16 byte update for the framer
// ---------------------------------------------------------------------------
package tpf_pkg;

  localparam int unsigned NumWords = 10;

  localparam logic [7:0]  SyncByte  = 8'hFF;
  localparam logic [7:0]  LenByte   = 8'h1A;
  localparam logic [15:0] CrcPoly   = 16'h8005;

  // byte positions inside a packet
  localparam logic [4:0] PosSync0   = 5'd0;
  localparam logic [4:0] PosSync1   = 5'd1;
  localparam logic [4:0] PosId      = 5'd2;
  localparam logic [4:0] PosLen     = 5'd3;
  localparam logic [4:0] PosWord0   = 5'd4;
  localparam logic [4:0] PosCrcHi   = 5'd24;
  localparam logic [4:0] PosCrcLo   = 5'd25;

  typedef logic [15:0] word_t;

  // one queued record: ten values plus the id byte in force at accept
  typedef struct packed {
    word_t [NumWords-1:0] words;
    logic [7:0]           device_id;
  } record_t;

  // crc-16/buypass, one byte in, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/tpf_if.sv
// ---------------------------------------------------------------------------
// tpf channel interfaces
// record input, byte output and id register write channels
// ---------------------------------------------------------------------------
interface tpf_rec_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading;
  logic [15:0] velocity_left;
  logic [15:0] velocity_right;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] gyro_x;
  logic [15:0] gyro_y;
  logic [15:0] gyro_z;
  logic [15:0] distance_left;
  logic [15:0] distance_right;

  modport source (output valid, heading, velocity_left, velocity_right, accel_x, accel_y,
                  gyro_x, gyro_y, gyro_z, distance_left, distance_right, input ready);
  modport sink (input valid, heading, velocity_left, velocity_right, accel_x, accel_y,
                gyro_x, gyro_y, gyro_z, distance_left, distance_right, output ready);
endinterface

interface tpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

interface tpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_id;

  modport source (output valid, device_id, input ready);
  modport sink (input valid, device_id, output ready);
endinterface

### rtl/tpf_queue.sv
// ---------------------------------------------------------------------------
// tpf_queue
// two-entry record queue between the accepting front and the serializer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tpf_pkg::record_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output tpf_pkg::record_t head_o
);

  tpf_pkg::record_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `ASSERT_CHK(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `ASSERT_CHK(a_no_pop_empty, clk_i, rst_ni, pop_i |-> avail_o, "pop from empty queue")
  `ASSERT_CHK(a_count_ptrs, clk_i, rst_ni,
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "fill count disagrees with pointers")

endmodule

### rtl/tpf_back.sv
// ---------------------------------------------------------------------------
// tpf_back
// packet serializer: one byte per cycle while the output is not stalled, crc-16 accumulated on the fly
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  tpf_pkg::record_t  head_i,
  output logic              pop_o,
  tpf_byte_if.source        out_o
);

  tpf_pkg::record_t rec_q;
  logic [4:0]       pos_q;
  logic             busy_q;
  logic [15:0]      crc_q;
  logic             ov_q;
  logic [7:0]       ob_q;
  logic             ol_q;

  logic             advance;
  logic             at_last;
  logic [3:0]       widx;
  logic [4:0]       woff;
  tpf_pkg::word_t   wsel;
  logic [7:0]       byte_d;

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = ob_q;
  assign out_o.last_byte = ol_q;

  // a byte moves into the output register when it is free or being taken
  assign advance = busy_q && (!ov_q || out_o.ready);
  assign at_last = (pos_q == tpf_pkg::PosCrcLo);
  assign pop_o   = avail_i && (!busy_q || (advance && at_last));

  // byte select for the current position
  always_comb begin
    woff   = pos_q - tpf_pkg::PosWord0;
    widx   = woff[4:1];
    wsel   = (widx < 4'(tpf_pkg::NumWords)) ? rec_q.words[4'(tpf_pkg::NumWords - 1) - widx]
                                            : 16'h0000;
    byte_d = pos_q[0] ? wsel[7:0] : wsel[15:8];
    case (pos_q)
      tpf_pkg::PosSync0,
      tpf_pkg::PosSync1: byte_d = tpf_pkg::SyncByte;
      tpf_pkg::PosId:    byte_d = rec_q.device_id;
      tpf_pkg::PosLen:   byte_d = tpf_pkg::LenByte;
      tpf_pkg::PosCrcHi: byte_d = crc_q[15:8];
      tpf_pkg::PosCrcLo: byte_d = crc_q[7:0];
      default: ;
    endcase
  end

  // control: position, busy flag, output valid and crc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 5'd0;
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      crc_q  <= 16'h0000;
    end else begin
      if (advance)             ov_q <= 1'b1;
      else if (out_o.ready)    ov_q <= 1'b0;
      if (pop_o) begin
        pos_q  <= 5'd0;
        busy_q <= 1'b1;
        crc_q  <= 16'h0000;
      end else if (advance) begin
        if (pos_q < tpf_pkg::PosCrcHi) crc_q <= tpf_pkg::crc_feed(crc_q, byte_d);
        if (at_last) begin
          pos_q  <= 5'd0;
          busy_q <= 1'b0;
        end else begin
          pos_q  <= pos_q + 5'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= head_i;
    if (advance) begin
      ob_q <= byte_d;
      ol_q <= at_last;
    end
  end

  `ASSERT_CHK(a_pos_range, clk_i, rst_ni, pos_q <= tpf_pkg::PosCrcLo, "byte position out of range")
  `ASSERT_CHK(a_load_clears, clk_i, rst_ni,
    pop_o |=> (pos_q == 5'd0) && (crc_q == 16'h0000) && busy_q, "record load not clean")
  `ASSERT_CHK(a_last_follows_crc, clk_i, rst_ni,
    (advance && at_last) |=> ov_q && ol_q, "last byte not flagged")

endmodule

### rtl/telemetry_packet_framer_crc16_unit.sv
// ---------------------------------------------------------------------------
// telemetry_packet_framer_crc16_unit
// frames a ten-word telemetry record into a 26-byte packet with crc-16
// ---------------------------------------------------------------------------
// channel  dir  payload                                  transfer
// in_i     in   ten 16-bit telemetry values              valid & ready
// out_o    out  out_byte[7:0], last_byte                 valid & ready
// cfg_i    in   device_id[7:0]                           valid & ready
//
// the byte serializer sends one packet byte per cycle while the consumer takes
// a byte every cycle, and records then follow with no gap. a two-entry queue
// lets up to two records be accepted while a packet is going out. reset
// clears control only, device_id resets to 1. an output stall holds the byte
// register and the serializer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module telemetry_packet_framer_crc16_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpf_rec_if.sink    in_i,
  tpf_cfg_if.sink    cfg_i,
  tpf_byte_if.source out_o
);

  logic [7:0]       dev_id_q;
  tpf_pkg::record_t entry;
  tpf_pkg::record_t head;
  logic             q_full;
  logic             q_avail;
  logic             q_pop;
  logic             push;

  // id register write port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dev_id_q <= 8'd1;
    else if (cfg_i.valid) dev_id_q <= cfg_i.device_id;
  end

  // front: accept a record and pack it with the current id
  assign in_i.ready = !q_full;
  assign push       = in_i.valid && !q_full;

  always_comb begin
    entry.words     = {in_i.heading, in_i.velocity_left, in_i.velocity_right,
                       in_i.accel_x, in_i.accel_y, in_i.gyro_x, in_i.gyro_y,
                       in_i.gyro_z, in_i.distance_left, in_i.distance_right};
    entry.device_id = dev_id_q;
  end

  tpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .avail_o     (q_avail),
    .head_o      (head)
  );

  tpf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .head_i  (head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  `ASSERT_CHK(a_ready_when_room, clk_i, rst_ni, !q_full |-> in_i.ready, "input stalled with room")
  `ASSERT_CHK(a_pop_needs_entry, clk_i, rst_ni, q_pop |-> q_avail, "serializer loaded from nothing")
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_o.valid, "output valid in reset")

endmodule

### tb/tpf_packet_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tpf_packet_checker
// watches the record, id and byte channels of the telemetry framer. every
// accepted record is framed into the 26 bytes it must produce, and every
// output transfer is compared with the oldest byte still awaited.
// ---------------------------------------------------------------------------
module tpf_packet_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpf_rec_if          rec_mon,
  tpf_cfg_if          cfg_mon,
  tpf_byte_if         byte_mon,
  output int unsigned mismatch_count_o,
  output int unsigned bytes_pending_o
);

  localparam int PacketLen = 26;
  localparam int CrcSpan   = 24;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } packet_byte_t;

  packet_byte_t awaited_bytes_q[$];
  logic [7:0]   device_id_q  = 8'd1;
  int unsigned  mismatch_cnt = 0;

  // crc-16/buypass, one bit at a time, msb first
  function automatic logic [15:0] crc16_buypass_update(input logic [15:0] crc,
                                                       input logic [7:0]  data);
    logic feedback;
    for (int i = 7; i >= 0; i--) begin
      feedback = crc[15] ^ data[i];
      crc      = {crc[14:0], 1'b0};
      if (feedback) crc = crc ^ tpf_pkg::CrcPoly;
    end
    return crc;
  endfunction

  // build the packet for one record and queue its bytes in transmit order
  function automatic void frame_record(input logic [7:0] id,
                                       input tpf_pkg::word_t words [tpf_pkg::NumWords]);
    logic [7:0]  pkt [PacketLen];
    logic [15:0] crc;
    pkt[tpf_pkg::PosSync0] = tpf_pkg::SyncByte;
    pkt[tpf_pkg::PosSync1] = tpf_pkg::SyncByte;
    pkt[tpf_pkg::PosId]    = id;
    pkt[tpf_pkg::PosLen]   = tpf_pkg::LenByte;
    for (int w = 0; w < tpf_pkg::NumWords; w++) begin
      pkt[tpf_pkg::PosWord0 + 2 * w]     = words[w][15:8];
      pkt[tpf_pkg::PosWord0 + 2 * w + 1] = words[w][7:0];
    end
    crc = '0;
    for (int p = 0; p < CrcSpan; p++) crc = crc16_buypass_update(crc, pkt[p]);
    pkt[tpf_pkg::PosCrcHi] = crc[15:8];
    pkt[tpf_pkg::PosCrcLo] = crc[7:0];
    for (int p = 0; p < PacketLen; p++) begin
      awaited_bytes_q.push_back('{out_byte: pkt[p], last_byte: (p == PacketLen - 1)});
    end
  endfunction

  // channel monitor: outputs are checked before new records are framed
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tpf_pkg::word_t words [tpf_pkg::NumWords];
    packet_byte_t   want;
    if (!rst_ni) begin
      device_id_q = 8'd1;
      awaited_bytes_q.delete();
    end else begin
      // byte transfer against the oldest awaited byte
      if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1) begin
        if (awaited_bytes_q.size() == 0) begin
          $error("byte transfer with no packet byte awaited: out_byte %02h, last_byte %0b",
                 byte_mon.out_byte, byte_mon.last_byte);
          mismatch_cnt++;
        end else begin
          want = awaited_bytes_q.pop_front();
          if (byte_mon.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.out_byte, byte_mon.out_byte);
            mismatch_cnt++;
          end
          if (byte_mon.last_byte !== want.last_byte) begin
            $error("last_byte mismatch: expected %0b, actual %0b",
                   want.last_byte, byte_mon.last_byte);
            mismatch_cnt++;
          end
        end
      end
      // record transfer, framed with the id in force at accept
      if (rec_mon.valid === 1'b1 && rec_mon.ready === 1'b1) begin
        words[0] = rec_mon.heading;
        words[1] = rec_mon.velocity_left;
        words[2] = rec_mon.velocity_right;
        words[3] = rec_mon.accel_x;
        words[4] = rec_mon.accel_y;
        words[5] = rec_mon.gyro_x;
        words[6] = rec_mon.gyro_y;
        words[7] = rec_mon.gyro_z;
        words[8] = rec_mon.distance_left;
        words[9] = rec_mon.distance_right;
        frame_record(device_id_q, words);
      end
      // id register write
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) device_id_q = cfg_mon.device_id;
    end
    mismatch_count_o <= mismatch_cnt;
    bytes_pending_o  <= awaited_bytes_q.size();
  end

endmodule

### tb/telemetry_packet_framer_crc16_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// telemetry_packet_framer_crc16_unit_tb
// drives telemetry records and device id writes into the framer while the
// byte consumer stalls on its own pattern; the checker beside the block
// predicts every packet byte and counts mismatches for the verdict.
// ---------------------------------------------------------------------------
module telemetry_packet_framer_crc16_unit_tb;

  localparam int RandomRecords = 160;
  localparam int RandomPhases  = 5;

  typedef enum int unsigned {
    SinkAlwaysReady,
    SinkCoinFlip,
    SinkBursty,
    SinkSlow
  } sink_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_count;
  int unsigned bytes_pending;
  int unsigned burst_left = 1;

  sink_mode_e  sink_mode  = SinkAlwaysReady;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  tpf_rec_if  rec_if ();
  tpf_cfg_if  cfg_if ();
  tpf_byte_if byte_if ();

  telemetry_packet_framer_crc16_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rec_if),
    .cfg_i  (cfg_if),
    .out_o  (byte_if)
  );

  tpf_packet_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_mon          (rec_if),
    .cfg_mon          (cfg_if),
    .byte_mon         (byte_if),
    .mismatch_count_o (mismatch_count),
    .bytes_pending_o  (bytes_pending)
  );

  always #5ns clk_i = ~clk_i;

  // byte consumer: stall pattern switches between random modes
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 160);
    end
    mode_left--;
    case (sink_mode)
      SinkAlwaysReady: byte_if.ready <= 1'b1;
      SinkCoinFlip:    byte_if.ready <= 1'($urandom_range(0, 1));
      SinkBursty: begin
        if (stall_left > 0) begin
          stall_left--;
          byte_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 8);
          byte_if.ready <= 1'b0;
        end else begin
          byte_if.ready <= 1'b1;
        end
      end
      default:         byte_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // one record transfer, then a random gap when the burst runs out
  task automatic send_record(input tpf_pkg::word_t words [tpf_pkg::NumWords]);
    int unsigned gap;
    rec_if.valid          <= 1'b1;
    rec_if.heading        <= words[0];
    rec_if.velocity_left  <= words[1];
    rec_if.velocity_right <= words[2];
    rec_if.accel_x        <= words[3];
    rec_if.accel_y        <= words[4];
    rec_if.gyro_x         <= words[5];
    rec_if.gyro_y         <= words[6];
    rec_if.gyro_z         <= words[7];
    rec_if.distance_left  <= words[8];
    rec_if.distance_right <= words[9];
    @(posedge clk_i);
    while (rec_if.ready !== 1'b1) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        rec_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_uniform(input tpf_pkg::word_t value);
    tpf_pkg::word_t words [tpf_pkg::NumWords];
    foreach (words[k]) words[k] = value;
    send_record(words);
  endtask

  // hold the sender until every awaited byte has gone out
  task automatic drain_packets();
    rec_if.valid <= 1'b0;
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_device_id(input logic [7:0] id);
    cfg_if.valid     <= 1'b1;
    cfg_if.device_id <= id;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // corner values often, otherwise any pattern
  function automatic tpf_pkg::word_t random_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return tpf_pkg::word_t'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    tpf_pkg::word_t words [tpf_pkg::NumWords];
    // known levels from time zero
    rec_if.valid          = 1'b0;
    rec_if.heading        = '0;
    rec_if.velocity_left  = '0;
    rec_if.velocity_right = '0;
    rec_if.accel_x        = '0;
    rec_if.accel_y        = '0;
    rec_if.gyro_x         = '0;
    rec_if.gyro_y         = '0;
    rec_if.gyro_z         = '0;
    rec_if.distance_left  = '0;
    rec_if.distance_right = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.device_id      = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed records under the reset id
    send_uniform(16'h0000);
    send_uniform(16'hFFFF);
    send_uniform(16'hAAAA);
    send_uniform(16'h5555);
    send_uniform(16'h8000);
    send_uniform(16'h7FFF);
    send_uniform(16'h00FF);
    send_uniform(16'hFF00);
    foreach (words[k]) begin
      words[k] = tpf_pkg::word_t'(16'h0001 << k) | tpf_pkg::word_t'(16'h8000 >> k);
    end
    send_record(words);
    foreach (words[k]) words[k] = tpf_pkg::word_t'(16'h1111 * k);
    send_record(words);
    drain_packets();

    // id extremes
    write_device_id(8'h00);
    send_uniform(16'hFFFF);
    send_uniform(16'h0000);
    drain_packets();
    write_device_id(8'hFF);
    send_uniform(16'h0000);
    send_uniform(16'hFFFF);
    drain_packets();

    // random records, each phase under its own id
    for (int ph = 0; ph < RandomPhases; ph++) begin
      write_device_id(8'($urandom()));
      for (int n = 0; n < RandomRecords / RandomPhases; n++) begin
        foreach (words[k]) words[k] = random_word();
        send_record(words);
      end
      drain_packets();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/tpf_pkg.sv
rtl/tpf_if.sv
rtl/tpf_queue.sv
rtl/tpf_back.sv
rtl/telemetry_packet_framer_crc16_unit.sv
tb/tpf_packet_checker.sv
tb/telemetry_packet_framer_crc16_unit_tb.sv
